[src/grbf_pkg.sv]
// Shared types and constants of the Gaussian radial basis network evaluator.
// No dependencies.
package grbf_pkg;

  localparam int unsigned DefNumInputs  = 4;
  localparam int unsigned DefNumBases   = 8;
  localparam int unsigned DefNumOutputs = 2;

  localparam logic [63:0] EpsDen  = 64'd281474977;
  localparam logic [63:0] EpsWsum = 64'd17;
  localparam logic [31:0] BfMax   = 32'd32 << 24;

  // Reciprocals scaled by 2^32 for exact division of small values by 6 and 24.
  localparam logic [31:0] Recip6  = 32'd715827883;
  localparam logic [31:0] Recip24 = 32'd178956971;

  typedef enum logic {
    OpLoad   = 1'b0,
    OpSample = 1'b1
  } op_e;

  // Control handed to the shared divider.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [63:0] rem;
  } div_rsp_t;

endpackage

[src/grbf_div.sv]
// Shared unsigned 64-bit restoring divider, one quotient bit per cycle.
// Depends on grbf_pkg.
module grbf_div
  import grbf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [63:0] quo_q, rem_q, den_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] trial;

  assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.num;
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_q <= trial[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= {rem_q[62:0], quo_q[63]};
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

[src/gaussian_rbf_network_eval.sv]
// Sequenced evaluation of all bases and outputs around one shared divider
// and one 32x32 multiplier. Depends on grbf_pkg and grbf_div.
// Loads and non-last samples are taken in the idle state. A last sample starts
// an evaluation of every basis and then every output on the shared divider, which
// serves every ratio and each output normalization whose weight sum reaches
// EpsWsum; the block is not ready meanwhile and results leave one per
// output through an output register.
module gaussian_rbf_network_eval
  import grbf_pkg::*;
#(
  parameter int unsigned NUM_INPUTS  = DefNumInputs,
  parameter int unsigned NUM_BASES   = DefNumBases,
  parameter int unsigned NUM_OUTPUTS = DefNumOutputs
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [11:0]        index_i,
  input  logic signed [31:0] value_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         output_index_o,
  output logic signed [47:0] output_value_o,
  output logic               last_output_o
);

  localparam int unsigned BlockWords = 2 * NUM_INPUTS + NUM_OUTPUTS;
  localparam int unsigned NumWords   = NUM_BASES * BlockWords;
  localparam int unsigned IW = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int unsigned BW = (NUM_BASES > 1) ? $clog2(NUM_BASES) : 1;
  localparam int unsigned OW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
  localparam int unsigned CW = (NUM_BASES * NUM_INPUTS > 1) ?
                               $clog2(NUM_BASES * NUM_INPUTS) : 1;
  localparam int unsigned WW = (NUM_BASES * NUM_OUTPUTS > 1) ?
                               $clog2(NUM_BASES * NUM_OUTPUTS) : 1;
  localparam int unsigned KW = $clog2(BlockWords + 1);

  typedef enum logic [4:0] {
    StIdle, StRd, StDiff, StSq, StSqR, StDivGo, StDivWait, StFrac, StAcc,
    StE0, StE1, StE2, StE3, StE4, StE5, StESq, StEDone,
    StORd, StOMul, StOAcc, StODiv, StOWait, StOSat, StOut
  } state_e;

  logic signed [31:0] center_mem [NUM_BASES*NUM_INPUTS];
  logic signed [31:0] radius_mem [NUM_BASES*NUM_INPUTS];
  logic signed [31:0] weight_mem [NUM_BASES*NUM_OUTPUTS];
  logic signed [31:0] sample_q [NUM_INPUTS];
  logic [24:0]        phi_q [NUM_BASES];

  state_e       state_q;
  logic [BW-1:0] b_q;
  logic [IW-1:0] j_q;
  logic [OW-1:0] k_q;
  logic [4:0]   cnt_q;
  logic signed [31:0] c_q, r_q, w_q;
  logic [32:0]  ad_q, ab_q;
  logic [63:0]  num_q, den_q, quo_q, rem_q;
  logic [31:0]  bf_q;
  logic [63:0]  t_q, t2_q, t3_q, p_q;
  logic signed [63:0] acc_q, ws_q;
  logic         neg_q, pos_sel_q;
  logic         out_valid_q;

  // Shared 32x32 unsigned multiplier.
  logic [31:0] ma, mb;
  logic [63:0] mp;
  assign mp = {32'd0, ma} * {32'd0, mb};

  div_req_t div_req;
  div_rsp_t div_rsp;
  grbf_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // Load address decode by comparing the index against each block start.
  logic [11:0] ld_basis;
  logic [KW-1:0] ld_off;
  always_comb begin
    ld_basis = '0;
    ld_off   = '0;
    for (int unsigned bb = 0; bb < NUM_BASES; bb++) begin
      if ({20'd0, index_i} >= bb * BlockWords) begin
        ld_basis = 12'(bb);
        ld_off   = KW'({20'd0, index_i} - bb * BlockWords);
      end
    end
  end

  logic acc_in;
  assign in_ready_o = (state_q == StIdle);
  assign acc_in     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (acc_in && op_e'(operation_i) == OpLoad && {20'd0, index_i} < NumWords) begin
      if (ld_off < KW'(2 * NUM_INPUTS)) begin
        if (ld_off[0])
          radius_mem[CW'(ld_basis * NUM_INPUTS + 32'(ld_off >> 1))] <= value_i;
        else
          center_mem[CW'(ld_basis * NUM_INPUTS + 32'(ld_off >> 1))] <= value_i;
      end else begin
        weight_mem[WW'(ld_basis * NUM_OUTPUTS + 32'(ld_off) - 2 * NUM_INPUTS)] <= value_i;
      end
    end
    if (acc_in && op_e'(operation_i) == OpSample && {20'd0, index_i} < NUM_INPUTS)
      sample_q[IW'(index_i)] <= value_i;
    if (state_q == StRd) begin
      c_q <= center_mem[CW'(32'(b_q) * NUM_INPUTS + 32'(j_q))];
      r_q <= radius_mem[CW'(32'(b_q) * NUM_INPUTS + 32'(j_q))];
    end
    if (state_q == StORd)
      w_q <= weight_mem[WW'(32'(b_q) * NUM_OUTPUTS + 32'(k_q))];
  end

  logic signed [32:0] dlt;
  assign dlt = 33'(sample_q[j_q]) - 33'(c_q);

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      StSq:  begin ma = ad_q[31:0]; mb = ad_q[31:0]; end
      StSqR: begin ma = ab_q[31:0]; mb = ab_q[31:0]; end
      StE1:  begin ma = t_q[31:0];  mb = t_q[31:0];  end
      StE2:  begin ma = t2_q[31:0]; mb = t_q[31:0];  end
      StE3:  begin ma = t3_q[31:0]; mb = t_q[31:0];  end
      StE4:  begin ma = t3_q[31:0]; mb = Recip6;     end
      StE5:  begin ma = t_q[31:0];  mb = Recip24;    end
      StESq: begin ma = p_q[31:0];  mb = p_q[31:0];  end
      StOMul: begin ma = w_q[31] ? 32'(-w_q) : w_q; mb = {7'd0, phi_q[b_q]}; end
      default: ;
    endcase
  end

  // Squares of 33-bit magnitudes: (a)^2 = lo^2 + 2*a32*lo*2^32 + a32*2^64.
  function automatic logic [65:0] sq33(input logic [32:0] a, input logic [63:0] lo2);
    logic [65:0] r;
    r = {2'd0, lo2};
    if (a[32]) r = r + ({34'd0, a[31:0]} << 33) + (66'd1 << 64);
    return r;
  endfunction

  logic [65:0] num_full, den_full;
  assign num_full = sq33(ad_q, mp);
  assign den_full = sq33(ab_q, mp);

  logic [63:0] q_bit;
  assign q_bit = rem_q << 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      b_q <= '0; j_q <= '0; k_q <= '0; cnt_q <= '0;
      div_req     <= '0;
      last_output_o <= 1'b0;
    end else begin
      div_req.start <= (state_q == StDivGo) ||
                       (state_q == StODiv && ws_q >= $signed(EpsWsum));
      unique case (state_q)
        StIdle: if (acc_in && op_e'(operation_i) == OpSample && last_i) begin
          b_q <= '0; j_q <= '0; bf_q <= '0; state_q <= StRd;
        end
        StRd:   state_q <= StDiff;
        StDiff: begin
          ad_q <= dlt[32] ? 33'(-dlt) : dlt;
          ab_q <= r_q[31] ? 33'(-34'(r_q)) : 33'(r_q);
          state_q <= StSq;
        end
        StSq: begin
          num_q <= num_full[63:0];
          state_q <= StSqR;
        end
        StSqR: begin
          den_q <= (den_full[63:0] < EpsDen) ? EpsDen : den_full[63:0];
          state_q <= StDivGo;
        end
        StDivGo: begin
          div_req.num <= num_q;
          div_req.den <= den_q;
          state_q <= StDivWait;
        end
        StDivWait: if (div_rsp.done) begin
          quo_q <= (div_rsp.quo >= 64'd32) ? {32'd0, BfMax} : div_rsp.quo;
          rem_q <= div_rsp.rem; cnt_q <= '0;
          state_q <= (div_rsp.quo >= 64'd32) ? StAcc : StFrac;
        end
        StFrac: begin
          // 24 fraction bits, one per cycle.
          if ({rem_q[63], q_bit} >= {1'b0, den_q}) begin
            rem_q <= q_bit - den_q; quo_q <= {quo_q[62:0], 1'b1};
          end else begin
            rem_q <= q_bit; quo_q <= {quo_q[62:0], 1'b0};
          end
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd23) state_q <= StAcc;
        end
        StAcc: begin
          if (quo_q > {32'd0, BfMax} || {32'd0, bf_q} + quo_q > {32'd0, BfMax})
            bf_q <= BfMax;
          else
            bf_q <= bf_q + quo_q[31:0];
          if (32'(j_q) == NUM_INPUTS - 1) begin
            j_q <= '0; state_q <= StE0;
          end else begin
            j_q <= j_q + 1'b1; state_q <= StRd;
          end
        end
        StE0: begin t_q <= {35'd0, bf_q[31:3]}; state_q <= StE1; end
        StE1: begin t2_q <= (mp + 64'd536870912) >> 30; state_q <= StE2; end
        StE2: begin t3_q <= (mp + 64'd536870912) >> 30; state_q <= StE3; end
        StE3: begin
          t_q  <= (mp + 64'd536870912) >> 30; // reused as t4
          p_q  <= 64'd1073741824 - t_q + (t2_q >> 1);
          state_q <= StE4;
        end
        StE4: begin
          p_q <= p_q - {32'd0, mp[63:32]};
          state_q <= StE5;
        end
        StE5: begin
          p_q <= p_q + {32'd0, mp[63:32]};
          cnt_q <= '0;
          state_q <= StESq;
        end
        StESq: begin
          p_q <= (mp + 64'd536870912) >> 30;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd8) state_q <= StEDone;
        end
        StEDone: begin
          phi_q[b_q] <= 25'((p_q + 64'd32) >> 6);
          bf_q <= '0;
          if (32'(b_q) == NUM_BASES - 1) begin
            b_q <= '0; k_q <= '0; acc_q <= '0; ws_q <= '0; state_q <= StORd;
          end else begin
            b_q <= b_q + 1'b1; state_q <= StRd;
          end
        end
        StORd:  state_q <= StOMul;
        StOMul: begin
          t_q <= mp; neg_q <= w_q[31]; state_q <= StOAcc;
        end
        StOAcc: begin
          acc_q <= neg_q ? acc_q - $signed(t_q) : acc_q + $signed(t_q);
          ws_q  <= ws_q + 64'(w_q);
          if (32'(b_q) == NUM_BASES - 1) begin
            b_q <= '0; state_q <= StODiv;
          end else begin
            b_q <= b_q + 1'b1; state_q <= StORd;
          end
        end
        StODiv: begin
          pos_sel_q <= acc_q[63];
          if (ws_q >= $signed(EpsWsum)) begin
            div_req.num <= acc_q[63] ? 64'(-acc_q) : acc_q;
            div_req.den <= ws_q;
            state_q <= StOWait;
          end else begin
            quo_q <= (acc_q[63] ? 64'(-acc_q) : acc_q) >> 24;
            state_q <= StOSat;
          end
        end
        StOWait: if (div_rsp.done) begin quo_q <= div_rsp.quo; state_q <= StOSat; end
        StOSat: begin
          if (pos_sel_q)
            output_value_o <= (quo_q > 64'd140737488355328) ? {1'b1, 47'd0}
                                : 48'(-quo_q);
          else
            output_value_o <= (quo_q > 64'd140737488355327) ? {1'b0, {47{1'b1}}}
                                : quo_q[47:0];
          output_index_o <= 4'(k_q);
          last_output_o  <= (32'(k_q) == NUM_OUTPUTS - 1);
          out_valid_q    <= 1'b1;
          state_q <= StOut;
        end
        StOut: if (out_ready_i) begin
          out_valid_q <= 1'b0;
          if (32'(k_q) == NUM_OUTPUTS - 1) begin
            state_q <= StIdle;
          end else begin
            k_q <= k_q + 1'b1; acc_q <= '0; ws_q <= '0; state_q <= StORd;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("result while ready");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(output_value_o))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> !div_rsp.done) else $error("divider done too early");

endmodule
